/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fsic_pkg.sv */
// Types and constants of the frame sequence integrity checker.
`default_nettype none
package fsic_pkg;

    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int PLD_W   = 64;
    localparam int SEQ_W   = 16;
    localparam int TOT_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 2 * BYTE_W;
    localparam int NUM_LANES = 3;  // three 16-bit words cover bytes 0 to 5
    localparam int CFG_W   = ID_W;

    localparam logic [ID_W-1:0]  MATCH_ID_RESET = 29'h100;
    localparam logic [LEN_W-1:0] REQ_LEN_RESET  = 4'd8;

    typedef enum logic {
        CFG_MATCH_ID = 1'b0,
        CFG_REQ_LEN  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_IN_ORDER = 3'd0,
        VERDICT_GAP      = 3'd1,
        VERDICT_STALE    = 3'd2,
        VERDICT_CHECKSUM = 3'd3,
        VERDICT_BAD_ID   = 3'd4,
        VERDICT_BAD_LEN  = 3'd5
    } verdict_t;

    // Outcome of the stateless checks on one frame.
    typedef struct packed {
        logic id_ok;
        logic len_ok;
        logic sum_ok;
    } check_t;

endpackage
`default_nettype wire

/* rtl/fsic_lane.sv */
// One checksum lane: folds a 16-bit payload word into an 8-bit XOR.
`default_nettype none
module fsic_lane
    import fsic_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    output logic      [BYTE_W-1:0] lane_xor
);

    assign lane_xor = word[WORD_W-1:BYTE_W] ^ word[BYTE_W-1:0];

endmodule
`default_nettype wire

/* rtl/fsic_merge.sv */
// Merging stage: combines the lane XORs and the identifier and length checks.
`default_nettype none
module fsic_merge
    import fsic_pkg::*;
(
    input  wire logic [NUM_LANES-1:0][BYTE_W-1:0] lane_xor,
    input  wire logic [BYTE_W-1:0]                sum_byte,
    input  wire logic [ID_W-1:0]                  frame_id,
    input  wire logic [LEN_W-1:0]                 frame_length,
    input  wire logic [ID_W-1:0]                  match_id,
    input  wire logic [LEN_W-1:0]                 required_length,
    output check_t                                check
);

    logic [BYTE_W-1:0] fold;

    always_comb
    begin
        fold = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            fold = fold ^ lane_xor[i];
        end
        check.id_ok  = (frame_id == match_id);
        check.len_ok = (frame_length == required_length);
        check.sum_ok = (fold == sum_byte);
    end

endmodule
`default_nettype wire

/* rtl/fsic_tracker.sv */
// Sequence tracker: holds the expected sequence and counters and the output register.
`default_nettype none
module fsic_tracker
    import fsic_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s1_valid,
    input  wire check_t            s1_check,
    input  wire logic [SEQ_W-1:0]  s1_seq,
    output logic                   s1_take,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output verdict_t               verdict,
    output logic      [SEQ_W-1:0]  gap_size,
    output logic      [SEQ_W-1:0]  frame_sequence,
    output logic      [SEQ_W-1:0]  next_expected,
    output logic      [TOT_W-1:0]  accepted_total,
    output logic      [TOT_W-1:0]  missed_total,
    output logic      [TOT_W-1:0]  checksum_error_total,
    output logic      [TOT_W-1:0]  stale_total,
    output logic      [TOT_W-1:0]  bad_id_total,
    output logic      [TOT_W-1:0]  bad_length_total
);

    localparam int CW = COUNTER_WIDTH;

    logic [SEQ_W-1:0] exp_reg, exp_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [CW-1:0]    miss_reg, miss_next;
    logic [CW-1:0]    csum_reg, csum_next;
    logic [CW-1:0]    stale_reg, stale_next;
    logic [CW-1:0]    bad_id_reg, bad_id_next;
    logic [CW-1:0]    bad_len_reg, bad_len_next;
    logic             out_valid_reg, out_valid_next;
    verdict_t         verdict_reg, verdict_next;
    logic [SEQ_W-1:0] gap_reg, gap_next;
    logic [SEQ_W-1:0] seq_reg;
    logic [SEQ_W-1:0] diff;

    // The output register is free when empty or when its item leaves this cycle.
    assign s1_take = s1_valid && (!out_valid_reg || !out_stall);
    assign diff    = s1_seq - exp_reg;

    always_comb
    begin
        exp_next     = exp_reg;
        acc_next     = acc_reg;
        miss_next    = miss_reg;
        csum_next    = csum_reg;
        stale_next   = stale_reg;
        bad_id_next  = bad_id_reg;
        bad_len_next = bad_len_reg;
        gap_next     = '0;
        verdict_next = VERDICT_BAD_ID;
        priority if (!s1_check.id_ok)
        begin
            verdict_next = VERDICT_BAD_ID;
            bad_id_next  = bad_id_reg + CW'(1);
        end
        else if (!s1_check.len_ok)
        begin
            verdict_next = VERDICT_BAD_LEN;
            bad_len_next = bad_len_reg + CW'(1);
        end
        else if (!s1_check.sum_ok)
        begin
            verdict_next = VERDICT_CHECKSUM;
            acc_next     = acc_reg + CW'(1);
            csum_next    = csum_reg + CW'(1);
        end
        else if (s1_seq == exp_reg)
        begin
            verdict_next = VERDICT_IN_ORDER;
            acc_next     = acc_reg + CW'(1);
            exp_next     = exp_reg + SEQ_W'(1);
        end
        else if (s1_seq > exp_reg)
        begin
            verdict_next = VERDICT_GAP;
            acc_next     = acc_reg + CW'(1);
            gap_next     = diff;
            miss_next    = miss_reg + CW'(diff);
            exp_next     = s1_seq + SEQ_W'(1);
        end
        else
        begin
            verdict_next = VERDICT_STALE;
            acc_next     = acc_reg + CW'(1);
            stale_next   = stale_reg + CW'(1);
        end

        if (s1_take)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            exp_reg       <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            csum_reg      <= '0;
            stale_reg     <= '0;
            bad_id_reg    <= '0;
            bad_len_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                exp_reg     <= exp_next;
                acc_reg     <= acc_next;
                miss_reg    <= miss_next;
                csum_reg    <= csum_next;
                stale_reg   <= stale_next;
                bad_id_reg  <= bad_id_next;
                bad_len_reg <= bad_len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            verdict_reg <= verdict_next;
            gap_reg     <= gap_next;
            seq_reg     <= s1_seq;
        end
    end

    // The reported totals are the low bits of the counters, zero-extended when narrower.
    assign out_valid            = out_valid_reg;
    assign verdict              = verdict_reg;
    assign gap_size             = gap_reg;
    assign frame_sequence       = seq_reg;
    assign next_expected        = exp_reg;
    assign accepted_total       = TOT_W'(acc_reg);
    assign missed_total         = TOT_W'(miss_reg);
    assign checksum_error_total = TOT_W'(csum_reg);
    assign stale_total          = TOT_W'(stale_reg);
    assign bad_id_total         = TOT_W'(bad_id_reg);
    assign bad_length_total     = TOT_W'(bad_len_reg);

endmodule
`default_nettype wire

/* rtl/frame_sequence_integrity_checker_unit.sv */
// Top level of the frame sequence integrity checker.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  frame_id, frame_length, payload
//   out       output     out_valid/out_stall verdict, gap_size, frame_sequence,
//                                           next_expected, six totals
//   cfg       input      cfg_we             cfg_index, cfg_data
//
// One item is accepted per cycle while in_stall is low; each result passes both stages.
// Identifier, length and checksum checks run in a first register stage; the sequence
// compare and counter update run in the second, one item per cycle while not stalled.
// Reset clears the expected sequence, all counters and both valid flags.
// A stalled output holds its item; the input stalls only when both stages are full.
`default_nettype none
module frame_sequence_integrity_checker_unit
    import fsic_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [ID_W-1:0]   frame_id,
    input  wire logic [LEN_W-1:0]  frame_length,
    input  wire logic [PLD_W-1:0]  payload,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [2:0]        verdict,
    output logic      [SEQ_W-1:0]  gap_size,
    output logic      [SEQ_W-1:0]  frame_sequence,
    output logic      [SEQ_W-1:0]  next_expected,
    output logic      [TOT_W-1:0]  accepted_total,
    output logic      [TOT_W-1:0]  missed_total,
    output logic      [TOT_W-1:0]  checksum_error_total,
    output logic      [TOT_W-1:0]  stale_total,
    output logic      [TOT_W-1:0]  bad_id_total,
    output logic      [TOT_W-1:0]  bad_length_total
);

    logic [ID_W-1:0]                  match_id_reg;
    logic [LEN_W-1:0]                 req_len_reg;
    logic [NUM_LANES-1:0][BYTE_W-1:0] lane_xor;
    check_t                           check;
    logic                             s1_valid_reg, s1_valid_next;
    check_t                           s1_check_reg;
    logic [SEQ_W-1:0]                 s1_seq_reg;
    logic                             s1_take;
    logic                             in_accept;
    verdict_t                         verdict_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_id_reg <= MATCH_ID_RESET;
            req_len_reg  <= REQ_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MATCH_ID: match_id_reg <= cfg_data;
                CFG_REQ_LEN:  req_len_reg  <= cfg_data[LEN_W-1:0];
                default:      match_id_reg <= match_id_reg;
            endcase
        end
    end

    // Bytes 0 to 5 are checked in three word lanes against byte 6.
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        fsic_lane u_lane (
            .word     (payload[PLD_W-1-g*WORD_W -: WORD_W]),
            .lane_xor (lane_xor[g])
        );
    end

    fsic_merge u_merge (
        .lane_xor        (lane_xor),
        .sum_byte        (payload[PLD_W-1-6*BYTE_W -: BYTE_W]),
        .frame_id        (frame_id),
        .frame_length    (frame_length),
        .match_id        (match_id_reg),
        .required_length (req_len_reg),
        .check           (check)
    );

    assign in_stall  = s1_valid_reg && !s1_take;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else
        begin
            s1_valid_next = s1_valid_reg && !s1_take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_check_reg <= check;
            s1_seq_reg   <= payload[PLD_W-1 -: SEQ_W];
        end
    end

    fsic_tracker #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_tracker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .s1_valid             (s1_valid_reg),
        .s1_check             (s1_check_reg),
        .s1_seq               (s1_seq_reg),
        .s1_take              (s1_take),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .verdict              (verdict_int),
        .gap_size             (gap_size),
        .frame_sequence       (frame_sequence),
        .next_expected        (next_expected),
        .accepted_total       (accepted_total),
        .missed_total         (missed_total),
        .checksum_error_total (checksum_error_total),
        .stale_total          (stale_total),
        .bad_id_total         (bad_id_total),
        .bad_length_total     (bad_length_total)
    );

    assign verdict = verdict_int;

endmodule
`default_nettype wire

/* rtl/fsic_checker.sv */
// Port-level assertions on the frame sequence integrity checker, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module fsic_checker
    import fsic_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [2:0]        verdict,
    input wire logic [SEQ_W-1:0]  gap_size,
    input wire logic [SEQ_W-1:0]  frame_sequence,
    input wire logic [SEQ_W-1:0]  next_expected,
    input wire logic [TOT_W-1:0]  missed_total
);

    // A held result keeps its verdict and missed total.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict) && $stable(missed_total), "held result changed")

    // Only a gap reports a nonzero gap size, and a gap is never empty.
    `ASSERT_IMPLY(a_gap_zero, out_valid && verdict != VERDICT_GAP, gap_size == '0, "gap size without gap")
    `ASSERT_IMPLY(a_gap_nonzero, out_valid && verdict == VERDICT_GAP, gap_size != '0 && next_expected == SEQ_W'(frame_sequence + SEQ_W'(1)), "gap result inconsistent")

    // An in-order frame moves the expected sequence just past itself.
    `ASSERT_IMPLY(a_in_order, out_valid && verdict == VERDICT_IN_ORDER, next_expected == SEQ_W'(frame_sequence + SEQ_W'(1)), "in-order result did not advance")

endmodule

bind frame_sequence_integrity_checker_unit fsic_checker u_fsic_checker (.*);
`default_nettype wire
